/* rtl/banked_gpio_controller_assert.svh */
// assertion macros for the gpio controller rtl
`ifndef BANKED_GPIO_CONTROLLER_ASSERT_SVH
`define BANKED_GPIO_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS
// checked property, quiet while reset is held
`define BGC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, also evaluated during reset
`define BGC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BGC_ASSERT(lbl, clk, rst_n, prop, msg)
`define BGC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/bgc_pkg.sv */
package bgc_pkg;

    // operation codes
    localparam logic [2:0] OP_WORD_RD = 3'd0;
    localparam logic [2:0] OP_WORD_WR = 3'd1;
    localparam logic [2:0] OP_PIN_RD  = 3'd2;
    localparam logic [2:0] OP_PIN_WR  = 3'd3;
    localparam logic [2:0] OP_SAMPLE  = 3'd4;

    // register type codes
    localparam logic [2:0] REG_OUT    = 3'd0;
    localparam logic [2:0] REG_OE     = 3'd1;
    localparam logic [2:0] REG_IN     = 3'd2;
    localparam logic [2:0] REG_DETECT = 3'd3;
    localparam logic [2:0] REG_POL    = 3'd4;
    localparam logic [2:0] REG_ENABLE = 3'd5;
    localparam logic [2:0] REG_CLEAR  = 3'd6;
    localparam logic [2:0] REG_STATUS = 3'd7;

    // word slots inside one bank entry of the state memory
    localparam int         N_WORDS = 7;
    localparam logic [2:0] W_OUT   = 3'd0;
    localparam logic [2:0] W_OE    = 3'd1;
    localparam logic [2:0] W_LEVEL = 3'd2;
    localparam logic [2:0] W_DET   = 3'd3;
    localparam logic [2:0] W_POL   = 3'd4;
    localparam logic [2:0] W_EN    = 3'd5;
    localparam logic [2:0] W_STAT  = 3'd6;

    // pin layout of the banks
    localparam int TABLE_BANKS = 6;
    localparam logic [6:0] BANK_LO_PIN [TABLE_BANKS] =
        '{7'd0, 7'd16, 7'd43, 7'd68, 7'd95, 7'd107};
    localparam logic [6:0] BANK_HI_PIN [TABLE_BANKS] =
        '{7'd15, 7'd42, 7'd67, 7'd94, 7'd106, 7'd121};

    typedef struct packed {
        logic [2:0]  operation;
        logic [2:0]  bank;
        logic [2:0]  reg_type;
        logic [31:0] write_data;
        logic [6:0]  pin_number;
        logic        pin_value;
        logic [31:0] pin_levels;
    } t_in_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
    } t_out_req;

    // decoded target of a request
    typedef struct packed {
        logic       hit;
        logic [2:0] bank;
        logic [4:0] bit_pos;
    } t_dec;

    // pins present in a bank, limited to the stored word width
    function automatic logic [31:0] bank_mask(input logic [2:0] b, input int wb);
        logic [31:0] m;
        int          n;
        m = '0;
        if (int'(b) < TABLE_BANKS) begin
            n = int'(BANK_HI_PIN[b]) - int'(BANK_LO_PIN[b]) + 1;
            m = (n >= 32) ? '1 : ((32'd1 << n) - 32'd1);
            if (wb < 32) begin
                m = m & ((32'd1 << wb) - 32'd1);
            end
        end
        return m;
    endfunction

endpackage

/* rtl/bgc_ram.sv */
module bgc_ram
    import bgc_pkg::*;
#(
    parameter int WIDTH = 224,
    parameter int DEPTH = 6,
    parameter int AW    = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rdata;
    logic             r_rd_valid;

    // storage and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    // per-entry valid bits, an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_rd_valid ? r_rdata : '0;

endmodule

/* rtl/bgc_decode.sv */
module bgc_decode
    import bgc_pkg::*;
#(
    parameter int NUM_BANKS = 6,
    parameter int WORD_BITS = 32
) (
    input  t_in_req i_req,
    output t_dec    o_dec
);

    logic [6:0] pin_off;

    always_comb begin
        o_dec   = '0;
        pin_off = '0;
        unique case (i_req.operation) inside
            OP_WORD_RD, OP_WORD_WR, OP_SAMPLE: begin
                o_dec.hit  = (int'(i_req.bank) < NUM_BANKS) &&
                             (int'(i_req.bank) < TABLE_BANKS);
                o_dec.bank = i_req.bank;
            end
            OP_PIN_RD, OP_PIN_WR: begin
                // bank ranges are disjoint, at most one matches
                for (int i = 0; i < TABLE_BANKS; i++) begin
                    if (i_req.pin_number >= BANK_LO_PIN[i] &&
                        i_req.pin_number <= BANK_HI_PIN[i]) begin
                        pin_off       = i_req.pin_number - BANK_LO_PIN[i];
                        o_dec.bank    = 3'(i);
                        o_dec.bit_pos = pin_off[4:0];
                        o_dec.hit     = (i < NUM_BANKS) && (int'(pin_off) < WORD_BITS);
                    end
                end
            end
            default: begin
                o_dec = '0;
            end
        endcase
    end

endmodule

/* rtl/bgc_alu.sv */
module bgc_alu
    import bgc_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  t_in_req                             i_req,
    input  t_dec                                i_dec,
    input  logic [WORD_BITS-1:0]                i_mask,
    input  logic [N_WORDS-1:0][WORD_BITS-1:0]   i_entry,
    output logic [N_WORDS-1:0][WORD_BITS-1:0]   o_entry,
    output logic                                o_we,
    output logic [31:0]                         o_read_data,
    output logic                                o_irq_bit
);

    logic                 has_reg;
    logic                 writable;
    logic [2:0]           idx;
    logic [WORD_BITS-1:0] cur;
    logic [WORD_BITS-1:0] cur_shift;
    logic [WORD_BITS-1:0] one;
    logic [WORD_BITS-1:0] wdata;
    logic [WORD_BITS-1:0] nw;
    logic [WORD_BITS-1:0] old;
    logic [WORD_BITS-1:0] pol;
    logic [WORD_BITS-1:0] det;
    logic [WORD_BITS-1:0] active;
    logic [WORD_BITS-1:0] edges;
    logic [WORD_BITS-1:0] hits;

    // register type to word slot
    always_comb begin
        has_reg = 1'b1;
        unique case (i_req.reg_type)
            REG_OUT:    idx = W_OUT;
            REG_OE:     idx = W_OE;
            REG_IN:     idx = W_LEVEL;
            REG_DETECT: idx = W_DET;
            REG_POL:    idx = W_POL;
            REG_ENABLE: idx = W_EN;
            REG_STATUS: idx = W_STAT;
            default: begin
                has_reg = 1'b0;
                idx     = W_OUT;
            end
        endcase
    end

    assign writable  = has_reg && (i_req.reg_type != REG_IN) && (i_req.reg_type != REG_STATUS);
    assign cur       = has_reg ? i_entry[idx] : '0;
    assign cur_shift = cur >> i_dec.bit_pos;
    assign one       = {{(WORD_BITS-1){1'b0}}, 1'b1} << i_dec.bit_pos;
    assign wdata     = i_req.write_data[WORD_BITS-1:0] & i_mask;

    // sample detection terms
    assign nw     = i_req.pin_levels[WORD_BITS-1:0] & i_mask;
    assign old    = i_entry[W_LEVEL];
    assign pol    = i_entry[W_POL];
    assign det    = i_entry[W_DET];
    assign active = (nw & pol) | (~nw & ~pol);
    assign edges  = ((nw & ~old) & pol) | ((~nw & old) & ~pol);
    assign hits   = (edges & det) | (active & ~det);

    // read-modify-write of one bank entry
    always_comb begin
        o_entry     = i_entry;
        o_we        = 1'b0;
        o_read_data = '0;
        if (i_dec.hit) begin
            unique case (i_req.operation)
                OP_WORD_RD: begin
                    o_read_data = 32'(cur & i_mask);
                end
                OP_WORD_WR: begin
                    o_we = 1'b1;
                    if (i_req.reg_type == REG_CLEAR) begin
                        o_entry[W_STAT] = i_entry[W_STAT] & ~wdata;
                    end else if (writable) begin
                        o_entry[idx] = wdata;
                    end
                end
                OP_PIN_RD: begin
                    o_read_data = {31'd0, cur_shift[0]};
                end
                OP_PIN_WR: begin
                    o_we = 1'b1;
                    if (i_req.reg_type == REG_CLEAR) begin
                        if (i_req.pin_value) begin
                            o_entry[W_STAT] = i_entry[W_STAT] & ~one;
                        end
                    end else if (writable) begin
                        o_entry[idx] = i_req.pin_value ? (i_entry[idx] | one)
                                                       : (i_entry[idx] & ~one);
                    end
                end
                OP_SAMPLE: begin
                    o_we             = 1'b1;
                    o_entry[W_STAT]  = i_entry[W_STAT] | (hits & i_mask);
                    o_entry[W_LEVEL] = nw;
                end
                default: begin
                    o_we = 1'b0;
                end
            endcase
        end
    end

    assign o_irq_bit = |(o_entry[W_STAT] & o_entry[W_EN]);

endmodule

/* rtl/banked_gpio_controller.sv */
// banked gpio controller, 122 pins in six banks
// input channel: i_in_valid / o_in_stall carry one request (word or pin
//   access, or a bank input sample); it is taken when valid is high and
//   stall is low
// output channel: o_out_valid / i_out_stall return one result per request,
//   read data and the irq line as it stands after that request
// result path: the state memory read for a taken request is registered,
//   then the update and write-back happen as the result is registered
// request flow: one request at a time, held by the read-modify-write of
//   the bank memory; a new request is taken in the cycle after the
//   previous one wrote back, while its result may still wait
// receiver stall: the result holds in the output register; a request in
//   flight waits to complete until that register is free, and o_in_stall
//   stays high meanwhile
// reset: all bank words read as zero right after reset through per-bank
//   valid bits, no clearing pass; the irq summary is clear, both channels are empty
module banked_gpio_controller
    import bgc_pkg::*;
#(
    parameter int NUM_BANKS = 6,
    parameter int WORD_BITS = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_req
);

    `include "banked_gpio_controller_assert.svh"

    localparam int AW    = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int WIDTH = N_WORDS * WORD_BITS;

    t_dec                              dec_in;
    t_dec                              r_dec;
    t_in_req                           r_req;
    logic                              r_busy;
    logic                              r_out_valid;
    t_out_req                          r_out;
    logic [NUM_BANKS-1:0]              r_irq_bank;
    logic [NUM_BANKS-1:0]              n_irq_bank;
    logic                              accept;
    logic                              done;
    logic                              ram_we;
    logic [AW-1:0]                     raddr;
    logic [N_WORDS-1:0][WORD_BITS-1:0] rd_entry;
    logic [N_WORDS-1:0][WORD_BITS-1:0] wr_entry;
    logic [31:0]                       mask_word;
    logic [WORD_BITS-1:0]              mask;
    logic                              alu_we;
    logic [31:0]                       alu_rd;
    logic                              alu_irq;

    assign accept      = i_in_valid && !r_busy;
    assign done        = r_busy && (!r_out_valid || !i_out_stall);
    assign ram_we      = done && alu_we;
    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // request decode on the input side, drives the memory read address
    bgc_decode #(
        .NUM_BANKS(NUM_BANKS),
        .WORD_BITS(WORD_BITS)
    ) u_decode (
        .i_req(i_in_req),
        .o_dec(dec_in)
    );

    assign raddr = dec_in.hit ? dec_in.bank[AW-1:0] : '0;

    // bank state memory, one entry of all bank words per bank
    bgc_ram #(
        .WIDTH(WIDTH),
        .DEPTH(NUM_BANKS),
        .AW(AW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rd_en(accept),
        .i_raddr(raddr),
        .o_rdata(rd_entry),
        .i_we   (ram_we),
        .i_waddr(r_dec.bank[AW-1:0]),
        .i_wdata(wr_entry)
    );

    assign mask_word = bank_mask(r_dec.bank, WORD_BITS);
    assign mask      = mask_word[WORD_BITS-1:0];

    // update of the bank entry read for the held request
    bgc_alu #(
        .WORD_BITS(WORD_BITS)
    ) u_alu (
        .i_req      (r_req),
        .i_dec      (r_dec),
        .i_mask     (mask),
        .i_entry    (rd_entry),
        .o_entry    (wr_entry),
        .o_we       (alu_we),
        .o_read_data(alu_rd),
        .o_irq_bit  (alu_irq)
    );

    // per-bank interrupt summary after this request
    always_comb begin
        n_irq_bank = r_irq_bank;
        if (ram_we) begin
            n_irq_bank[r_dec.bank[AW-1:0]] = alu_irq;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_irq_bank  <= '0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_irq_bank <= n_irq_bank;
        end
    end

    // held request and output payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in_req;
            r_dec <= dec_in;
        end
        if (done) begin
            r_out.read_data <= alu_rd;
            r_out.irq       <= |n_irq_bank;
        end
    end

    `BGC_ASSERT(a_accept_busy, i_clk, i_rst_n, accept |=> r_busy, "request taken but not held")
    `BGC_ASSERT(a_write_in_flight, i_clk, i_rst_n, ram_we |-> (r_busy && !accept), "memory write outside a request")
    `BGC_ASSERT(a_result_after_busy, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_busy), "result without a request")
    `BGC_ASSERT(a_hold_on_stall, i_clk, i_rst_n, (r_busy && r_out_valid && i_out_stall) |=> r_busy, "request dropped while output full")
    `BGC_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (!r_busy && !r_out_valid), "not idle after reset")

endmodule
